// ===== src/ptra_pkg.sv =====
// ---------------------------------------------------------------------------
// ptra_pkg: shared types and constants
// Table geometry, mode and status codes, controller states and the
// command/status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package ptra_pkg;

   localparam int KERNEL_TABLES     = 3;
   localparam int ENTRIES_PER_TABLE = 1024;
   localparam int TABLE_DEPTH       = KERNEL_TABLES * ENTRIES_PER_TABLE;
   localparam int ADDR_W            = $clog2(TABLE_DEPTH);
   localparam int IDX_W             = $clog2(TABLE_DEPTH + 1);
   localparam int CNT_W             = 13;
   localparam int CMP_W             = (IDX_W > CNT_W) ? IDX_W : CNT_W;
   localparam int DIR_FIRST         = 768;

   localparam logic [31:0] WINDOW_BASE = 32'hC000_0000;
   localparam logic [31:0] PAGE_BYTES  = 32'h0000_1000;

   typedef enum logic [1:0] {
      MODE_MAP   = 2'd0,
      MODE_UNMAP = 2'd1,
      MODE_XLATE = 2'd2,
      MODE_HIGH  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_NO_RUN  = 2'd1,
      STAT_LOCKED  = 2'd2,
      STAT_OUTSIDE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      RES_NONE,
      RES_MAP,
      RES_NO_RUN,
      RES_OUTSIDE,
      RES_LOCKED,
      RES_UNMAP,
      RES_XLATE,
      RES_HIGH
   } res_type;

   typedef enum logic [3:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_MAP_SCAN,
      FSM_MAP_WRITE,
      FSM_UNMAP_RD,
      FSM_UNMAP_CHK,
      FSM_XLATE_RD,
      FSM_XLATE_CHK,
      FSM_HIGH_SCAN,
      FSM_RESP
   } fsm_type;

   typedef struct packed {
      logic    load;
      logic    clr_wr;
      logic    scan;
      logic    map_wr;
      logic    rd;
      logic    unmap_clr;
      res_type res;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic req_outside;
      logic found;
      logic scan_done;
      logic idx_end;
      logic locked;
      logic endblk;
      logic wr_last;
   } sts_type;

endpackage

// ===== src/ptra_ctrl.sv =====
// ---------------------------------------------------------------------------
// ptra_ctrl: sequencing controller
// Walks clear, scan, write and walk phases and issues datapath commands.
// ---------------------------------------------------------------------------
module ptra_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [1:0]          req_mode,
   input  ptra_pkg::sts_type   sts,
   output ptra_pkg::cmd_type   cmd,
   output logic                busy,
   output logic                rsp_valid
);

   ptra_pkg::fsm_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptra_pkg::FSM_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ptra_pkg::FSM_CLEAR: begin
            if (sts.clr_last) state_in = ptra_pkg::FSM_IDLE;
         end
         ptra_pkg::FSM_IDLE: begin
            if (start) begin
               case (ptra_pkg::mode_type'(req_mode))
                  ptra_pkg::MODE_MAP:   state_in = ptra_pkg::FSM_MAP_SCAN;
                  ptra_pkg::MODE_UNMAP: state_in = sts.req_outside ? ptra_pkg::FSM_RESP
                                                                   : ptra_pkg::FSM_UNMAP_RD;
                  ptra_pkg::MODE_XLATE: state_in = sts.req_outside ? ptra_pkg::FSM_RESP
                                                                   : ptra_pkg::FSM_XLATE_RD;
                  default:              state_in = ptra_pkg::FSM_HIGH_SCAN;
               endcase
            end
         end
         ptra_pkg::FSM_MAP_SCAN: begin
            if (sts.found)          state_in = ptra_pkg::FSM_MAP_WRITE;
            else if (sts.scan_done) state_in = ptra_pkg::FSM_RESP;
         end
         ptra_pkg::FSM_MAP_WRITE: begin
            if (sts.wr_last) state_in = ptra_pkg::FSM_RESP;
         end
         ptra_pkg::FSM_UNMAP_RD: begin
            state_in = sts.idx_end ? ptra_pkg::FSM_RESP : ptra_pkg::FSM_UNMAP_CHK;
         end
         ptra_pkg::FSM_UNMAP_CHK: begin
            if (sts.locked || sts.endblk) state_in = ptra_pkg::FSM_RESP;
            else                          state_in = ptra_pkg::FSM_UNMAP_RD;
         end
         ptra_pkg::FSM_XLATE_RD:  state_in = ptra_pkg::FSM_XLATE_CHK;
         ptra_pkg::FSM_XLATE_CHK: state_in = ptra_pkg::FSM_RESP;
         ptra_pkg::FSM_HIGH_SCAN: begin
            if (sts.scan_done) state_in = ptra_pkg::FSM_RESP;
         end
         ptra_pkg::FSM_RESP: state_in = ptra_pkg::FSM_IDLE;
         default:            state_in = ptra_pkg::FSM_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd = '{load: 1'b0, clr_wr: 1'b0, scan: 1'b0, map_wr: 1'b0, rd: 1'b0,
              unmap_clr: 1'b0, res: ptra_pkg::RES_NONE};
      case (state_ff)
         ptra_pkg::FSM_CLEAR: cmd.clr_wr = 1'b1;
         ptra_pkg::FSM_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if ((req_mode == ptra_pkg::MODE_UNMAP || req_mode == ptra_pkg::MODE_XLATE)
                   && sts.req_outside)
                  cmd.res = ptra_pkg::RES_OUTSIDE;
            end
         end
         ptra_pkg::FSM_MAP_SCAN: begin
            cmd.scan = 1'b1;
            if (!sts.found && sts.scan_done) cmd.res = ptra_pkg::RES_NO_RUN;
         end
         ptra_pkg::FSM_MAP_WRITE: begin
            cmd.map_wr = 1'b1;
            if (sts.wr_last) cmd.res = ptra_pkg::RES_MAP;
         end
         ptra_pkg::FSM_UNMAP_RD: begin
            if (sts.idx_end) cmd.res = ptra_pkg::RES_OUTSIDE;
            else             cmd.rd  = 1'b1;
         end
         ptra_pkg::FSM_UNMAP_CHK: begin
            if (sts.locked) begin
               cmd.res = ptra_pkg::RES_LOCKED;
            end else begin
               cmd.unmap_clr = 1'b1;
               if (sts.endblk) cmd.res = ptra_pkg::RES_UNMAP;
            end
         end
         ptra_pkg::FSM_XLATE_RD:  cmd.rd  = 1'b1;
         ptra_pkg::FSM_XLATE_CHK: cmd.res = ptra_pkg::RES_XLATE;
         ptra_pkg::FSM_HIGH_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) cmd.res = ptra_pkg::RES_HIGH;
         end
         default: ;
      endcase
   end

   assign busy      = (state_ff != ptra_pkg::FSM_IDLE);
   assign rsp_valid = (state_ff == ptra_pkg::FSM_RESP);

endmodule

// ===== src/ptra_dp.sv =====
// ---------------------------------------------------------------------------
// ptra_dp: table datapath
// Entry memory, scan pipeline, run tracking, walk counters, result regs.
// ---------------------------------------------------------------------------
module ptra_dp (
   input  logic                clock,
   input  logic                reset,
   input  ptra_pkg::cmd_type   cmd,
   input  logic [1:0]          req_mode,
   input  logic [31:0]         req_phys_addr,
   input  logic [23:0]         req_size_bytes,
   input  logic [11:0]         req_entry_flags,
   input  logic [31:0]         req_virt_addr,
   output ptra_pkg::sts_type   sts,
   output logic [1:0]          rsp_status,
   output logic [31:0]         rsp_value
);

   localparam int AW = ptra_pkg::ADDR_W;
   localparam int IW = ptra_pkg::IDX_W;
   localparam int CW = ptra_pkg::CNT_W;
   localparam int MW = ptra_pkg::CMP_W;

   logic [31:0] mem [ptra_pkg::TABLE_DEPTH];

   logic [IW-1:0]  idx_ff, idx_in;
   logic           rvalid_ff, rvalid_in;
   logic [AW-1:0]  eval_idx_ff;
   logic [IW-1:0]  run_ff, run_in;
   logic [CW-1:0]  count_ff, wcnt_ff;
   logic [IW-1:0]  ucnt_ff;
   logic [19:0]    addr_ff;
   logic [11:0]    flags_ff, offs_ff;
   logic [AW-1:0]  start_ff;
   logic [31:0]    top_ff, top_in;
   logic [1:0]     mode_ff;
   logic [31:0]    rdata_ff;
   logic [1:0]     status_ff;
   logic [31:0]    value_ff;

   logic [9:0]     va_dir, va_rel;
   logic [IW-1:0]  va_idx;
   logic           free, found, found_ld, mem_we, mem_re;
   logic [AW-1:0]  map_start;
   logic [31:0]    masked, map_entry, wdata;

   // window decode of the request address
   assign va_dir = req_virt_addr[31:22];
   assign va_rel = va_dir - 10'(ptra_pkg::DIR_FIRST);
   assign va_idx = IW'({va_rel, req_virt_addr[21:12]});

   assign free      = !(rdata_ff[0] | rdata_ff[11]);
   assign found     = rvalid_ff && free && (mode_ff == ptra_pkg::MODE_MAP)
                      && ((MW'(run_ff) + MW'(1)) == MW'(count_ff));
   assign found_ld  = found && cmd.scan;
   assign map_start = AW'(MW'(eval_idx_ff) + MW'(1) - MW'(count_ff));
   assign masked    = rdata_ff & ~32'h7ff;
   assign top_in    = (rvalid_ff && masked > top_ff) ? masked : top_ff;
   assign run_in    = !rvalid_ff ? run_ff : (free ? run_ff + IW'(1) : '0);

   assign sts.clr_last    = (idx_ff == IW'(ptra_pkg::TABLE_DEPTH - 1));
   assign sts.req_outside = (va_dir < 10'(ptra_pkg::DIR_FIRST))
                            || ({1'b0, va_rel} >= 11'(ptra_pkg::KERNEL_TABLES));
   assign sts.found       = found;
   assign sts.scan_done   = rvalid_ff && (eval_idx_ff == AW'(ptra_pkg::TABLE_DEPTH - 1));
   assign sts.idx_end     = (idx_ff == IW'(ptra_pkg::TABLE_DEPTH));
   assign sts.locked      = rdata_ff[11];
   assign sts.endblk      = rdata_ff[10];
   assign sts.wr_last     = (wcnt_ff == count_ff - CW'(1));

   assign map_entry = {addr_ff, 12'h000} | {20'h0, flags_ff} | 32'h1
                      | (sts.wr_last ? 32'h400 : 32'h0);
   assign wdata     = cmd.map_wr ? map_entry : 32'h0;
   assign mem_we    = cmd.clr_wr | cmd.map_wr | cmd.unmap_clr;
   assign mem_re    = (cmd.scan && !sts.idx_end) || cmd.rd;
   assign rvalid_in = cmd.scan && !sts.idx_end && !found_ld;

   always_comb begin
      idx_in = idx_ff;
      if (cmd.load) begin
         if (req_mode == ptra_pkg::MODE_MAP || req_mode == ptra_pkg::MODE_HIGH)
            idx_in = '0;
         else
            idx_in = va_idx;
      end else if (found_ld) begin
         idx_in = IW'(map_start);
      end else if (mem_we || (cmd.scan && !sts.idx_end)) begin
         idx_in = idx_ff + IW'(1);
      end
   end

   // entry memory, one port
   always_ff @(posedge clock) begin
      if (mem_we) mem[idx_ff[AW-1:0]] <= wdata;
      if (mem_re) rdata_ff <= mem[idx_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         idx_ff    <= idx_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      eval_idx_ff <= idx_ff[AW-1:0];
      if (cmd.load) begin
         run_ff   <= '0;
         top_ff   <= '0;
         wcnt_ff  <= '0;
         ucnt_ff  <= '0;
         count_ff <= CW'(req_size_bytes[23:12]) + CW'(1);
         addr_ff  <= req_phys_addr[31:12];
         offs_ff  <= req_phys_addr[11:0];
         flags_ff <= req_entry_flags;
         mode_ff  <= req_mode;
      end else begin
         if (cmd.scan) begin
            run_ff <= run_in;
            top_ff <= top_in;
         end
         if (found_ld) start_ff <= map_start;
         if (cmd.map_wr) begin
            wcnt_ff <= wcnt_ff + CW'(1);
            addr_ff <= addr_ff + 20'd1;
         end
         if (cmd.unmap_clr) ucnt_ff <= ucnt_ff + IW'(1);
      end
   end

   // result registers
   always_ff @(posedge clock) begin
      case (cmd.res)
         ptra_pkg::RES_MAP: begin
            status_ff <= ptra_pkg::STAT_OK;
            value_ff  <= ptra_pkg::WINDOW_BASE + 32'({start_ff, 12'h000})
                         + {20'h0, offs_ff};
         end
         ptra_pkg::RES_NO_RUN: begin
            status_ff <= ptra_pkg::STAT_NO_RUN;
            value_ff  <= '0;
         end
         ptra_pkg::RES_OUTSIDE: begin
            status_ff <= ptra_pkg::STAT_OUTSIDE;
            value_ff  <= '0;
         end
         ptra_pkg::RES_LOCKED: begin
            status_ff <= ptra_pkg::STAT_LOCKED;
            value_ff  <= '0;
         end
         ptra_pkg::RES_UNMAP: begin
            status_ff <= ptra_pkg::STAT_OK;
            value_ff  <= 32'(ucnt_ff) + 32'd1;
         end
         ptra_pkg::RES_XLATE: begin
            status_ff <= ptra_pkg::STAT_OK;
            value_ff  <= rdata_ff & ~32'hfff;
         end
         ptra_pkg::RES_HIGH: begin
            status_ff <= ptra_pkg::STAT_OK;
            value_ff  <= top_in + ptra_pkg::PAGE_BYTES;
         end
         default: ;
      endcase
   end

   assign rsp_status = status_ff;
   assign rsp_value  = value_ff;

endmodule

// ===== src/page_table_run_allocator.sv =====
// ---------------------------------------------------------------------------
// page_table_run_allocator: kernel page table with run allocation
// Operation: map scans the entry memory, one entry a cycle, then writes
//   one entry a page; unmap reads and checks each entry walked; translate
//   reads and checks one entry; highest free scans the whole table.
// Throughput: one item at a time, set by the controller, which takes start only in idle.
// Reset: a clearing pass writes zero to all TABLE_DEPTH (3072) entries,
//   one a cycle, with busy high. The receiver cannot stall results.
// ---------------------------------------------------------------------------
module page_table_run_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_phys_addr,
   input  logic [23:0] req_size_bytes,
   input  logic [11:0] req_entry_flags,
   input  logic [31:0] req_virt_addr,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_value
);

   // command and status bundles between controller and datapath
   ptra_pkg::cmd_type cmd;
   ptra_pkg::sts_type sts;

   // controller: clear pass, scans, writes and the unmap walk
   ptra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_mode  (req_mode),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // datapath: entry memory, run tracking, result registers
   ptra_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_mode        (req_mode),
      .req_phys_addr   (req_phys_addr),
      .req_size_bytes  (req_size_bytes),
      .req_entry_flags (req_entry_flags),
      .req_virt_addr   (req_virt_addr),
      .sts             (sts),
      .rsp_status      (rsp_status),
      .rsp_value       (rsp_value)
   );

endmodule
